// ===== sv/bvu_pkg.sv =====
// Shared constants, types and codes for the boid velocity update block.
package bvu_pkg;

  // Table depth; a power of two so the entry index wraps by masking.
  localparam int MAX_BOIDS = 64;
  localparam int AW        = $clog2(MAX_BOIDS);
  localparam int NW        = $clog2(MAX_BOIDS + 1);
  localparam int FS_W      = 7;
  localparam int CMP_W     = (NW > FS_W) ? NW : FS_W;

  localparam int Q_W       = 32;
  localparam int GAIN_W    = 31;
  localparam int ENTRY_W   = 4 * Q_W;
  localparam int VSUM_W    = AW + 33;
  localparam int SEP_W     = AW + 34;
  localparam int V_W       = 64;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 32;
  localparam int SQ_W      = 64;

  localparam int CFG_IDX_W = 3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOCK_SIZE = 3'd0,
    CFG_COH_GAIN   = 3'd1,
    CFG_ALIGN_GAIN = 3'd2,
    CFG_SEP_RADIUS = 3'd3,
    CFG_MAX_SPEED  = 3'd4
  } cfg_idx_t;

endpackage

// ===== sv/bvu_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module bvu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bvu_div.sv =====
// Unsigned restoring divider, two quotient bits per cycle.
module bvu_div import bvu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  localparam int STEPS = DIV_NUM_W / 2;
  localparam int CW    = $clog2(STEPS);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic [DIV_DEN_W:0]   s1;
  logic [DIV_DEN_W:0]   s2;

  // One restoring step: shift in a numerator bit, subtract when it fits.
  function automatic logic [DIV_DEN_W:0] div_step(input logic [DIV_DEN_W-1:0] r,
                                                  input logic b,
                                                  input logic [DIV_DEN_W-1:0] d);
    logic [DIV_DEN_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      return {1'b1, DIV_DEN_W'(t - {1'b0, d})};
    end
    return {1'b0, t[DIV_DEN_W-1:0]};
  endfunction

  assign s1 = div_step(rem, quo[DIV_NUM_W-1], den_r);
  assign s2 = div_step(s1[DIV_DEN_W-1:0], quo[DIV_NUM_W-2], den_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo   <= num;
        den_r <= den;
        rem   <= '0;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        quo <= {quo[DIV_NUM_W-3:0], s1[DIV_DEN_W], s2[DIV_DEN_W]};
        rem <= s2[DIV_DEN_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/bvu_sqrt.sv =====
// Integer square root, one result bit per cycle.
module bvu_sqrt import bvu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   x,
  output logic              done,
  output logic [SQ_W/2-1:0] root
);

  logic [SQ_W-1:0] xr;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] bitr;
  logic [SQ_W-1:0] trial;
  logic            busy;

  assign trial = res + bitr;
  assign root  = res[SQ_W/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xr   <= x;
        res  <= '0;
        bitr <= SQ_W'(1) << (SQ_W - 2);
        busy <= 1'b1;
      end else if (busy) begin
        if (xr >= trial) begin
          xr  <= xr - trial;
          res <= (res >> 1) + bitr;
        end else begin
          res <= res >> 1;
        end
        bitr <= bitr >> 2;
        if (bitr[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/boid_velocity_update.sv =====
// Top level of the boid velocity update block: boid table, sequencer and datapath.
//
// Usage. Input words arrive on in_valid/in_ready. A load word (op = 0) writes
// position and velocity of one table entry and returns nothing. An update word
// (op = 1) names a boid and returns one output word on out_valid/out_ready
// carrying the new velocity, normalized to max_speed, or zero with zero_speed
// set when the summed vector is zero.
// Configuration words on cfg_valid/cfg_ready are always taken and must only be
// written while the block is idle.
// An update reads the table once per boid of the flock through a single read
// port, drains the walk pipeline, forms the mean and the final scaling in two
// radix-4 dividers, normalizes the summed vector and takes a bit-serial square
// root; a zero sum skips the normalization, the root and the final scaling.
// One update is in flight at a time; in_ready is high only when idle.
// Reset clears the control state and the registers to their reset values;
// the table itself is not cleared and must be loaded before it is used.
// A finished result waits in the output register while the receiver stalls;
// the block then returns to idle and accepts loads or updates meanwhile, and
// the next update holds in its final state until the register is free.
module boid_velocity_update import bvu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [5:0]           boid_index,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   vel_x,
  input  logic signed [31:0]   vel_y,
  input  logic signed [31:0]   target_x,
  input  logic signed [31:0]   target_y,
  input  logic                 player_present,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   new_vel_x,
  output logic signed [31:0]   new_vel_y,
  output logic                 zero_speed,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_SELF, S_COH, S_WALK, S_DRAIN, S_MEAN, S_MEAN_W, S_ALIGN, S_SUM,
    S_MAG, S_NORM, S_SQ, S_SQRT, S_SQRT_W, S_SCALE, S_NDIV, S_NDIV_W, S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [FS_W-1:0]   flock_size;
  logic [GAIN_W-1:0] cohesion_gain;
  logic [GAIN_W-1:0] alignment_gain;
  logic [GAIN_W-1:0] separation_radius;
  logic [GAIN_W-1:0] max_speed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flock_size        <= FS_W'(2);
      cohesion_gain     <= GAIN_W'(655);
      alignment_gain    <= GAIN_W'(8192);
      separation_radius <= GAIN_W'(655360);
      max_speed         <= GAIN_W'(262144);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FLOCK_SIZE: flock_size        <= cfg_data[FS_W-1:0];
        CFG_COH_GAIN:   cohesion_gain     <= cfg_data;
        CFG_ALIGN_GAIN: alignment_gain    <= cfg_data;
        CFG_SEP_RADIUS: separation_radius <= cfg_data;
        CFG_MAX_SPEED:  max_speed         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input handshake and entry index (table depth is a power of two).
  logic            in_fire;
  logic [AW+5:0]   idx_wide;
  logic [AW-1:0]   in_idx;
  logic [CMP_W-1:0] fs_w;
  logic [CMP_W-1:0] n_clamp;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign idx_wide = (AW + 6)'(boid_index);
  assign in_idx   = idx_wide[AW-1:0];
  assign fs_w     = CMP_W'(flock_size);
  assign n_clamp  = (fs_w < CMP_W'(2)) ? CMP_W'(2) :
                    (fs_w > CMP_W'(MAX_BOIDS)) ? CMP_W'(MAX_BOIDS) : fs_w;

  // Boid table: {pos_x, pos_y, vel_x, vel_y} per entry.
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [NW-1:0]      walk_b;

  assign ram_we    = in_fire && (op == OP_LOAD);
  assign ram_raddr = (state == S_WALK) ? walk_b[AW-1:0] : in_idx;

  bvu_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BOIDS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_idx),
    .wdata ({pos_x, pos_y, vel_x, vel_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic signed [31:0] rd_px, rd_py, rd_vx, rd_vy;
  assign rd_px = ram_rdata[4*Q_W-1:3*Q_W];
  assign rd_py = ram_rdata[3*Q_W-1:2*Q_W];
  assign rd_vx = ram_rdata[2*Q_W-1:Q_W];
  assign rd_vy = ram_rdata[Q_W-1:0];

  // Update context.
  logic [AW-1:0]      e_r;
  logic [NW-1:0]      n_r;
  logic signed [31:0] tx, ty, px, py, ux, uy;
  logic               player_r;
  logic [61:0]        r2;

  // Neighbour walk pipeline.
  logic                     s1_valid;
  logic [AW-1:0]            s1_b;
  logic                     s2_valid, s2_near;
  logic signed [32:0]       s2_dx, s2_dy;
  logic [30:0]              s2_adx, s2_ady;
  logic                     s3_valid;
  logic signed [32:0]       s3_dx, s3_dy;
  logic [61:0]              s3_sqx, s3_sqy;
  logic signed [VSUM_W-1:0] svx, svy;
  logic signed [SEP_W-1:0]  sepx, sepy;

  logic signed [32:0] w_dx, w_dy;
  logic [32:0]        w_adx, w_ady;
  logic               w_near, w_skip;

  assign w_dx   = {rd_px[31], rd_px} - {px[31], px};
  assign w_dy   = {rd_py[31], rd_py} - {py[31], py};
  assign w_adx  = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
  assign w_ady  = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
  assign w_near = (w_adx < {2'b00, separation_radius}) &&
                  (w_ady < {2'b00, separation_radius});
  assign w_skip = (s1_b == e_r);

  // Cohesion and alignment products.
  logic signed [32:0] coh_dx, coh_dy;
  logic signed [31:0] coh_g, al_g;
  logic signed [64:0] cprod_x, cprod_y;
  logic signed [48:0] cx, cy;
  logic signed [32:0] mx, my;
  logic signed [33:0] al_dx, al_dy;
  logic signed [65:0] aprod_x, aprod_y;
  logic signed [49:0] alx, aly;

  assign coh_dx  = {tx[31], tx} - {px[31], px};
  assign coh_dy  = {ty[31], ty} - {py[31], py};
  assign coh_g   = {1'b0, cohesion_gain};
  assign al_g    = {1'b0, alignment_gain};
  assign cprod_x = coh_dx * coh_g;
  assign cprod_y = coh_dy * coh_g;
  assign al_dx   = {mx[32], mx} - 34'(ux);
  assign al_dy   = {my[32], my} - 34'(uy);
  assign aprod_x = al_dx * al_g;
  assign aprod_y = al_dy * al_g;

  // Summed vector and normalization.
  logic signed [V_W-1:0] vx, vy;
  logic                  negx, negy;
  logic [V_W-1:0]        ax, ay, amax;
  logic [59:0]           sqx, sqy;
  logic [31:0]           len;
  logic [60:0]           mulx, muly;
  logic                  zero_r;
  logic signed [31:0]    ox, oy;

  assign amax = (ax > ay) ? ax : ay;

  // Shared dividers: mean of velocities, then the final scaling.
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num_x, div_num_y, quo_x, quo_y;
  logic [DIV_DEN_W-1:0] div_den_x, div_den_y;
  logic                 div_done_x, div_done_y;
  logic [VSUM_W-1:0]    svx_mag, svy_mag;

  assign svx_mag   = svx[VSUM_W-1] ? VSUM_W'(-svx) : VSUM_W'(svx);
  assign svy_mag   = svy[VSUM_W-1] ? VSUM_W'(-svy) : VSUM_W'(svy);
  assign div_start = (state == S_MEAN) || (state == S_NDIV);
  assign div_num_x = (state == S_MEAN) ? DIV_NUM_W'(svx_mag) : DIV_NUM_W'(mulx);
  assign div_num_y = (state == S_MEAN) ? DIV_NUM_W'(svy_mag) : DIV_NUM_W'(muly);
  assign div_den_x = (state == S_MEAN) ? DIV_DEN_W'(n_r - NW'(1)) : len;
  assign div_den_y = div_den_x;

  bvu_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num_x), .den(div_den_x),
    .done(div_done_x), .quo(quo_x)
  );

  bvu_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num_y), .den(div_den_y),
    .done(div_done_y), .quo(quo_y)
  );

  logic                sq_start, sq_done;
  logic [SQ_W-1:0]     sq_in;
  logic [SQ_W/2-1:0]   sq_root;

  assign sq_start = (state == S_SQRT);
  assign sq_in    = SQ_W'(sqx) + SQ_W'(sqy);

  bvu_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .x(sq_in), .done(sq_done), .root(sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
    end else begin
      // A word taken by the receiver frees the register, unless a new one is loaded now.
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      // Walk pipeline: table data, distance test, squares, separation sum.
      s1_valid <= (state == S_WALK);
      s2_valid <= s1_valid && !w_skip;
      if (s1_valid && !w_skip) begin
        svx     <= svx + VSUM_W'(rd_vx);
        svy     <= svy + VSUM_W'(rd_vy);
        s2_dx   <= w_dx;
        s2_dy   <= w_dy;
        s2_adx  <= w_adx[30:0];
        s2_ady  <= w_ady[30:0];
        s2_near <= w_near;
      end
      s3_valid <= s2_valid && s2_near;
      s3_sqx   <= s2_adx * s2_adx;
      s3_sqy   <= s2_ady * s2_ady;
      s3_dx    <= s2_dx;
      s3_dy    <= s2_dy;
      if (s3_valid && ((63'(s3_sqx) + 63'(s3_sqy)) < 63'(r2))) begin
        sepx <= sepx - SEP_W'(s3_dx);
        sepy <= sepy - SEP_W'(s3_dy);
      end

      case (state)
        S_IDLE: begin
          if (in_fire && (op == OP_UPDATE)) begin
            e_r      <= in_idx;
            n_r      <= NW'(n_clamp);
            tx       <= target_x;
            ty       <= target_y;
            player_r <= player_present;
            r2       <= separation_radius * separation_radius;
            svx      <= '0;
            svy      <= '0;
            sepx     <= '0;
            sepy     <= '0;
            walk_b   <= '0;
            state    <= S_SELF;
          end
        end
        S_SELF: begin
          px    <= rd_px;
          py    <= rd_py;
          ux    <= rd_vx;
          uy    <= rd_vy;
          state <= S_COH;
        end
        S_COH: begin
          cx    <= cprod_x[64:16];
          cy    <= cprod_y[64:16];
          state <= S_WALK;
        end
        S_WALK: begin
          s1_b <= walk_b[AW-1:0];
          if (walk_b == n_r - NW'(1)) begin
            state <= S_DRAIN;
          end else begin
            walk_b <= walk_b + NW'(1);
          end
        end
        S_DRAIN: begin
          if (!s1_valid && !s2_valid && !s3_valid) begin
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          state <= S_MEAN_W;
        end
        S_MEAN_W: begin
          if (div_done_x && div_done_y) begin
            mx    <= svx[VSUM_W-1] ? 33'(-quo_x[32:0]) : quo_x[32:0];
            my    <= svy[VSUM_W-1] ? 33'(-quo_y[32:0]) : quo_y[32:0];
            state <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          alx   <= aprod_x[65:16];
          aly   <= aprod_y[65:16];
          state <= S_SUM;
        end
        S_SUM: begin
          vx    <= V_W'(ux) + V_W'(cx) + V_W'(alx) + (player_r ? V_W'(sepx) : '0);
          vy    <= V_W'(uy) + V_W'(cy) + V_W'(aly) + (player_r ? V_W'(sepy) : '0);
          state <= S_MAG;
        end
        S_MAG: begin
          negx <= vx[V_W-1];
          negy <= vy[V_W-1];
          ax   <= vx[V_W-1] ? V_W'(-vx) : V_W'(vx);
          ay   <= vy[V_W-1] ? V_W'(-vy) : V_W'(vy);
          if (vx == '0 && vy == '0) begin
            zero_r <= 1'b1;
            ox     <= '0;
            oy     <= '0;
            state  <= S_OUT;
          end else begin
            zero_r <= 1'b0;
            state  <= S_NORM;
          end
        end
        S_NORM: begin
          // Bring the larger magnitude into [2^29, 2^30), eight bits or one at a time.
          if (amax >= (V_W'(1) << 38)) begin
            ax <= ax >> 8;
            ay <= ay >> 8;
          end else if (amax >= (V_W'(1) << 30)) begin
            ax <= ax >> 1;
            ay <= ay >> 1;
          end else if (amax < (V_W'(1) << 21)) begin
            ax <= ax << 8;
            ay <= ay << 8;
          end else if (amax < (V_W'(1) << 29)) begin
            ax <= ax << 1;
            ay <= ay << 1;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sqx   <= ax[29:0] * ax[29:0];
          sqy   <= ay[29:0] * ay[29:0];
          state <= S_SQRT;
        end
        S_SQRT: begin
          state <= S_SQRT_W;
        end
        S_SQRT_W: begin
          if (sq_done) begin
            len   <= sq_root;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          mulx  <= ax[29:0] * max_speed;
          muly  <= ay[29:0] * max_speed;
          state <= S_NDIV;
        end
        S_NDIV: begin
          state <= S_NDIV_W;
        end
        S_NDIV_W: begin
          if (div_done_x && div_done_y) begin
            ox    <= negx ? 32'(-quo_x[31:0]) : quo_x[31:0];
            oy    <= negy ? 32'(-quo_y[31:0]) : quo_y[31:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            new_vel_x  <= ox;
            new_vel_y  <= oy;
            zero_speed <= zero_r;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/bvu_checker.sv =====
// Port-level checker for the boid velocity update block, with its bind.
module bvu_checker import bvu_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 op,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [31:0]   new_vel_x,
  input logic signed [31:0]   new_vel_y,
  input logic                 zero_speed
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_vel_x) && $stable(new_vel_y))
    else $error("output word changed while stalled");

  // A zero-length sum gives a zero velocity.
  a_zero_vel: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_speed |-> new_vel_x == 0 && new_vel_y == 0)
    else $error("zero_speed with nonzero velocity");

  // A load produces no output word.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_LOAD && !out_valid |=> !out_valid)
    else $error("load produced an output word");

  // An accepted update holds off further input.
  a_update_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_UPDATE |=> !in_ready)
    else $error("input taken while an update is running");

endmodule

bind boid_velocity_update bvu_checker u_bvu_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
  .out_valid(out_valid), .out_ready(out_ready), .new_vel_x(new_vel_x),
  .new_vel_y(new_vel_y), .zero_speed(zero_speed)
);

// ===== tb/sv/boid_velocity_update_test.sv =====
// Testbench for the boid velocity update block: directed table, random phases, self-checking.
module boid_velocity_update_test;
  import bvu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous ceiling on the run.
  localparam int CYCLE_LIMIT  = 2000000;
  // Wait that covers the longest update, for the largest flock.
  localparam int SETTLE_WAIT  = 400;
  localparam int HOLD_CYCLES  = 3000;
  localparam int PHASE_ITEMS  = 100;
  localparam int MAX_PRINTED  = 30;

  logic clk, rst;
  logic in_valid, in_ready;
  logic op;
  logic [5:0] boid_index;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y, target_x, target_y;
  logic player_present;
  logic out_valid, out_ready;
  logic signed [31:0] new_vel_x, new_vel_y;
  logic zero_speed;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0] cfg_data;

  boid_velocity_update dut (.*);

  // One expected output word.
  typedef struct {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               zero;
  } velocity_t;

  // One row of the directed table. Rows with has_value carry a result typed in by hand.
  typedef struct {
    logic               op;
    logic [5:0]         idx;
    logic signed [31:0] px, py, vx, vy, tx, ty;
    logic               player;
    logic               has_value;
    velocity_t          value;
  } stim_row_t;

  // Our own copy of the boid table and of the registers.
  logic signed [31:0] tab_px [MAX_BOIDS];
  logic signed [31:0] tab_py [MAX_BOIDS];
  logic signed [31:0] tab_vx [MAX_BOIDS];
  logic signed [31:0] tab_vy [MAX_BOIDS];
  logic [6:0]          reg_flock;
  longint unsigned     reg_coh, reg_align, reg_radius, reg_speed;

  velocity_t pending_velocities[$];
  int mismatches, results_seen, updates_sent, loads_sent, zero_results;
  int cycle_count;
  bit hold_output;

  // Clock and the watchdog on the cycle count.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, pending_velocities.size());
      $display("** boid_velocity_update: FAILED **");
      $finish;
    end
  end

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("[%0d] mismatch: %s", cycle_count, what);
  endtask

  // Integer square root, rounded down, one result bit per pass.
  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned magnitude(input longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  // Works out the new velocity of boid e from the current table and registers.
  function automatic velocity_t steer(input int e, input logic signed [31:0] tx,
                                      input logic signed [31:0] ty, input logic player);
    velocity_t res;
    int n;
    longint px, py, ux, uy, cx, cy, svx, svy, sepx, sepy, dx, dy, mx, my, alx, aly, sx, sy;
    longint unsigned adx, ady, r2, ax, ay, len, ox, oy;
    n = (reg_flock < 2) ? 2 : (reg_flock > MAX_BOIDS) ? MAX_BOIDS : int'(reg_flock);
    px = tab_px[e]; py = tab_py[e]; ux = tab_vx[e]; uy = tab_vy[e];
    r2 = reg_radius * reg_radius;
    // Cohesion pulls toward the target; an arithmetic shift is a floor division.
    cx = ((longint'(tx) - px) * longint'(reg_coh)) >>> 16;
    cy = ((longint'(ty) - py) * longint'(reg_coh)) >>> 16;
    svx = 0; svy = 0; sepx = 0; sepy = 0;
    for (int b = 0; b < n; b++) begin
      if (b == e) continue;
      svx += longint'(tab_vx[b]);
      svy += longint'(tab_vy[b]);
      dx = longint'(tab_px[b]) - px;
      dy = longint'(tab_py[b]) - py;
      adx = magnitude(dx);
      ady = magnitude(dy);
      if (adx < reg_radius && ady < reg_radius && adx * adx + ady * ady < r2) begin
        sepx -= dx;
        sepy -= dy;
      end
    end
    // The mean divides by n - 1 even when the updated boid lies outside the flock.
    mx = svx / longint'(n - 1);
    my = svy / longint'(n - 1);
    alx = ((mx - ux) * longint'(reg_align)) >>> 16;
    aly = ((my - uy) * longint'(reg_align)) >>> 16;
    sx = ux + cx + alx;
    sy = uy + cy + aly;
    if (player) begin
      sx += sepx;
      sy += sepy;
    end
    if (sx == 0 && sy == 0) begin
      res.vx = '0; res.vy = '0; res.zero = 1'b1;
      return res;
    end
    // Bring the larger magnitude into [2^29, 2^30) before the root.
    ax = magnitude(sx);
    ay = magnitude(sy);
    while (((ax > ay) ? ax : ay) >= (64'd1 << 30)) begin
      ax >>= 1; ay >>= 1;
    end
    while (((ax > ay) ? ax : ay) < (64'd1 << 29)) begin
      ax <<= 1; ay <<= 1;
    end
    len = floor_root(ax * ax + ay * ay);
    if (len == 0) len = 1;
    ox = (ax * reg_speed) / len;
    oy = (ay * reg_speed) / len;
    res.vx = (sx < 0) ? -ox[31:0] : ox[31:0];
    res.vy = (sy < 0) ? -oy[31:0] : oy[31:0];
    res.zero = 1'b0;
    return res;
  endfunction

  // Offers one input word after a random gap and updates the prediction on acceptance.
  task automatic send_word(input stim_row_t w);
    int gap;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= w.op; boid_index <= w.idx;
    pos_x <= w.px; pos_y <= w.py; vel_x <= w.vx; vel_y <= w.vy;
    target_x <= w.tx; target_y <= w.ty; player_present <= w.player;
    do @(posedge clk); while (!in_ready);
    if (w.op == OP_LOAD) begin
      tab_px[w.idx] = w.px; tab_py[w.idx] = w.py;
      tab_vx[w.idx] = w.vx; tab_vy[w.idx] = w.vy;
      loads_sent++;
    end else begin
      pending_velocities.push_back(w.has_value ? w.value : steer(w.idx, w.tx, w.ty, w.player));
      updates_sent++;
    end
  endtask

  // Writes one register; the caller lowers valid after its last write.
  task automatic write_reg(input cfg_idx_t idx, input logic [GAIN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FLOCK_SIZE: reg_flock  = data[6:0];
      CFG_COH_GAIN:   reg_coh    = data;
      CFG_ALIGN_GAIN: reg_align  = data;
      CFG_SEP_RADIUS: reg_radius = data;
      CFG_MAX_SPEED:  reg_speed  = data;
      default: ;
    endcase
  endtask

  // Registers change only once every expected word is back and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_velocities.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic configure(input logic [GAIN_W-1:0] flock, input logic [GAIN_W-1:0] coh,
                           input logic [GAIN_W-1:0] align, input logic [GAIN_W-1:0] radius,
                           input logic [GAIN_W-1:0] speed);
    settle();
    write_reg(CFG_FLOCK_SIZE, flock);
    write_reg(CFG_COH_GAIN, coh);
    write_reg(CFG_ALIGN_GAIN, align);
    write_reg(CFG_SEP_RADIUS, radius);
    write_reg(CFG_MAX_SPEED, speed);
    cfg_valid <= 1'b0;
  endtask

  // A Q16.16 value that is near zero, at an extreme, or anything at all.
  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3, 4: return $urandom();
      default: return int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  function automatic stim_row_t random_word(input bit load);
    stim_row_t w;
    int n;
    n = (reg_flock < 2) ? 2 : (reg_flock > MAX_BOIDS) ? MAX_BOIDS : int'(reg_flock);
    w.op = load ? OP_LOAD : OP_UPDATE;
    // Mostly flock members, sometimes any entry of the table.
    w.idx = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, MAX_BOIDS - 1))
                                        : 6'($urandom_range(0, n - 1));
    w.px = pick_q16(); w.py = pick_q16(); w.vx = pick_q16(); w.vy = pick_q16();
    w.tx = pick_q16(); w.ty = pick_q16();
    w.player = 1'($urandom_range(0, 1));
    w.has_value = 1'b0;
    w.value = '{default: '0};
    return w;
  endfunction

  // Receiver: a random stall before each word, and one long hold-off on request.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compares every accepted output word with the oldest expectation.
  always @(posedge clk) begin
    velocity_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (zero_speed) zero_results++;
      if (pending_velocities.size() == 0) begin
        report($sformatf("unexpected word %h %h %b", new_vel_x, new_vel_y, zero_speed));
      end else begin
        want = pending_velocities.pop_front();
        if (new_vel_x !== want.vx)
          report($sformatf("new_vel_x %h, expected %h", new_vel_x, want.vx));
        if (new_vel_y !== want.vy)
          report($sformatf("new_vel_y %h, expected %h", new_vel_y, want.vy));
        if (zero_speed !== want.zero)
          report($sformatf("zero_speed %b, expected %b", zero_speed, want.zero));
      end
    end
  end

  // Main sequence: reset, table fill, directed rows, then random phases.
  initial begin
    stim_row_t directed[$];
    stim_row_t w;
    cycle_count = 0;
    rst = 1'b1;
    in_valid = 1'b0; op = OP_LOAD; boid_index = '0;
    pos_x = '0; pos_y = '0; vel_x = '0; vel_y = '0;
    target_x = '0; target_y = '0; player_present = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    hold_output = 1'b0;
    reg_flock = 7'd2; reg_coh = 655; reg_align = 8192;
    reg_radius = 655360; reg_speed = 262144;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every entry is written before any update reads it.
    for (int i = 0; i < MAX_BOIDS; i++) begin
      w = random_word(1'b1);
      w.idx = 6'(i);
      send_word(w);
    end

    // Directed rows under the reset register values (flock of two, max speed 4.0).
    // Two boids at rest on one spot with the target there too: the sum is zero.
    directed.push_back('{OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0}});
    directed.push_back('{OP_LOAD, 1, 0, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0}});
    directed.push_back('{OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 1}});
    directed.push_back('{OP_UPDATE, 1, 0, 0, 0, 0, 0, 0, 1, 1, '{0, 0, 1}});
    // Both moving at 1.0 along x: alignment is zero, the result is max speed along x.
    directed.push_back('{OP_LOAD, 0, 0, 0, 32'sh10000, 0, 0, 0, 0, 0, '{0, 0, 0}});
    directed.push_back('{OP_LOAD, 1, 0, 0, 32'sh10000, 0, 0, 0, 0, 0, '{0, 0, 0}});
    directed.push_back('{OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{262144, 0, 0}});
    // The same along minus y.
    directed.push_back('{OP_LOAD, 0, 0, 0, 0, -32'sh10000, 0, 0, 0, 0, '{0, 0, 0}});
    directed.push_back('{OP_LOAD, 1, 0, 0, 0, -32'sh10000, 0, 0, 0, 0, '{0, 0, 0}});
    directed.push_back('{OP_UPDATE, 1, 0, 0, 0, 0, 0, 0, 0, 1, '{0, -262144, 0}});
    // Opposite corners of the number range, checked by the predictor.
    directed.push_back('{OP_LOAD, 0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
                         32'sh8000_0000, 0, 0, 0, 0, '{0, 0, 0}});
    directed.push_back('{OP_LOAD, 1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                         32'sh7fff_ffff, 0, 0, 0, 0, '{0, 0, 0}});
    directed.push_back('{OP_UPDATE, 0, 0, 0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 1, 0,
                         '{0, 0, 0}});
    directed.push_back('{OP_UPDATE, 1, 0, 0, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 1, 0,
                         '{0, 0, 0}});
    // A boid outside the flock, and a close neighbor that pushes when a player is present.
    directed.push_back('{OP_UPDATE, 63, 0, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0}});
    directed.push_back('{OP_LOAD, 0, 0, 0, 32'sh4000, 32'sh2000, 0, 0, 0, 0, '{0, 0, 0}});
    directed.push_back('{OP_LOAD, 1, 32'sh10000, 32'sh10000, 0, 0, 0, 0, 0, 0, '{0, 0, 0}});
    directed.push_back('{OP_UPDATE, 0, 0, 0, 0, 0, 32'sh50000, -32'sh30000, 1, 0,
                         '{0, 0, 0}});
    directed.push_back('{OP_UPDATE, 0, 0, 0, 0, 0, 32'sh50000, -32'sh30000, 0, 0,
                         '{0, 0, 0}});
    foreach (directed[i]) send_word(directed[i]);

    // Random phases, each under its own register setting; extremes included.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: configure(8, 655, 8192, 655360, 262144);
        1: configure(64, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
        2: configure(0, 0, 0, 0, 0);
        3: configure(1, 31'($urandom()), 31'($urandom()), 31'($urandom()),
                     31'($urandom()));
        4: configure(127, 31'($urandom_range(0, 65536)), 31'($urandom_range(0, 65536)),
                     31'($urandom_range(0, 32'h0040_0000)),
                     31'($urandom_range(1, 32'h0010_0000)));
        5: configure(31'($urandom()), 31'($urandom()), 31'($urandom()), 31'($urandom()),
                     31'($urandom()));
        default: configure(31'($urandom_range(2, 64)), 31'($urandom_range(0, 4096)),
                           31'($urandom_range(0, 65536)),
                           31'($urandom_range(0, 32'h0100_0000)),
                           31'($urandom_range(0, 32'h0100_0000)));
      endcase
      // Hold the output off once, long enough for the block to stall its input.
      if (phase == 4) hold_output = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_word(random_word($urandom_range(0, 99) < 35));
    end

    in_valid <= 1'b0;
    while (pending_velocities.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("%0d loads and %0d updates sent, %0d velocity words checked (%0d zero)",
             loads_sent, updates_sent, results_seen, zero_results);
    $display("seven register settings with extremes, one long output hold-off, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("** boid_velocity_update: PASSED **");
    end else begin
      $display("** boid_velocity_update: FAILED **");
    end
    $finish;
  end

endmodule
